// ===== rtl/acit_pkg.sv =====
// Shared widths, register indexes, outcome codes and payload types for the cone/box test.
package acit_pkg;

    localparam int COORD_BITS     = 32;
    localparam int AXIS_BITS      = 16;
    localparam int AXIS_FRAC      = 14;
    localparam int TAN_BITS       = 16;
    localparam int TAN_FRAC       = 8;
    localparam int LEN_BITS       = COORD_BITS - 1;
    localparam int CFG_DATA_BITS  = COORD_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int OUTCOME_BITS   = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_X   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_Y   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_Z   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAN      = 3'd7;

    localparam logic [AXIS_BITS-1:0] AXIS_X_RESET = 16'd16384;
    localparam logic [TAN_BITS-1:0]  TAN_RESET    = 16'd256;

    localparam logic [OUTCOME_BITS-1:0] OUT_BEHIND     = 3'd0;
    localparam logic [OUTCOME_BITS-1:0] OUT_ORIGIN_IN  = 3'd1;
    localparam logic [OUTCOME_BITS-1:0] OUT_TOO_FAR    = 3'd2;
    localparam logic [OUTCOME_BITS-1:0] OUT_AXIAL_MISS = 3'd3;
    localparam logic [OUTCOME_BITS-1:0] OUT_OUTSIDE    = 3'd4;
    localparam logic [OUTCOME_BITS-1:0] OUT_IN_CONE    = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_min_z;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_max_y;
        logic signed [COORD_BITS-1:0] box_max_z;
    } box_item_t;

    typedef struct packed {
        logic                    hit;
        logic [OUTCOME_BITS-1:0] outcome;
    } test_result_t;

endpackage

// ===== rtl/acit_square.sv =====
// Two-stage pipelined squarer built from half-width partial products.
module acit_square #(
    parameter int W = 33
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [W-1:0]   din,
    output logic        [2*W-1:0] dout
);

    localparam int H = (W + 1) / 2;
    localparam int L = W - H;

    logic [W-1:0]     mag;
    logic [H-1:0]     lo;
    logic [L-1:0]     hi;
    logic [2*H-1:0]   ll_reg;
    logic [W-1:0]     lh_reg;
    logic [2*L-1:0]   hh_reg;
    logic [2*W-1:0]   dout_reg;

    assign mag = din[W-1] ? W'(-din) : W'(din);
    assign lo  = mag[H-1:0];
    assign hi  = mag[W-1:H];

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg   <= (2*H)'(lo) * (2*H)'(lo);
            lh_reg   <= W'(hi) * W'(lo);
            hh_reg   <= (2*L)'(hi) * (2*L)'(hi);
            dout_reg <= {hh_reg, {(2*H){1'b0}}} + ((2*W)'(lh_reg) << (H + 1))
                        + (2*W)'(ll_reg);
        end
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/acit_sqrt.sv =====
// Pipelined restoring square root, one root bit per stage, with remainder flag.
module acit_sqrt #(
    parameter int W = 68
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [W-1:0]     din,
    output logic [W/2-1:0]   root,
    output logic             rem_nz
);

    localparam int N  = W / 2;
    localparam int RW = N + 2;

    logic [RW-1:0] rem_reg  [N];
    logic [N-1:0]  root_reg [N];
    logic [W-1:0]  opnd_reg [N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic [N-1:0]  root_in;
        logic [1:0]    pair;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign pair    = din[W-1:W-2];
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign pair    = opnd_reg[k-1][W-1:W-2];
        end

        assign rem_sh = {rem_in[RW-3:0], pair};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[N-2:0], ge};
            end
        end

        if (k < N - 1) begin : g_opnd
            if (k == 0) begin : g_load
                always_ff @(posedge aclk) begin
                    if (en) begin
                        opnd_reg[k] <= din << 2;
                    end
                end
            end else begin : g_shift
                always_ff @(posedge aclk) begin
                    if (en) begin
                        opnd_reg[k] <= opnd_reg[k-1] << 2;
                    end
                end
            end
        end
    end

    assign root   = root_reg[N-1];
    assign rem_nz = |rem_reg[N-1];

endmodule

// ===== rtl/aabb_cone_intersect_test.sv =====
// Top level: pipelined conservative box versus bounded cone test.
//
// Usage notes
// - s_ channel: one box (min and max corners, signed Q23.8) per transfer.
// - m_ channel: one result per box, in order: hit flag and a 3-bit outcome
//   (behind miss, origin inside, too far, axial range miss, outside cone,
//   in cone).
// - Config: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle,
//   no wait states. Write only while no box is in flight.
// - Throughput: one box per cycle while the pipe is not held. The depth
//   is set by the square root of the squared box diagonal, one root bit
//   per stage (34 stages), plus the dot product, square and compare
//   stages around it.
// - Stall: the whole pipeline moves on one enable. A two-entry output
//   buffer lets input transfers continue while one result waits; only a
//   full buffer with m_ready low holds the pipe, and nothing is dropped.
// - Reset (aresetn low, synchronous): all stage valids and the output
//   buffer clear; registers return to apex 0, axis +x, length 0, tan 1.0.
module aabb_cone_intersect_test (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  acit_pkg::box_item_t                     s_payload,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output acit_pkg::test_result_t                  m_payload,
    input  logic                                    cfg_wr_en,
    input  logic [acit_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [acit_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

    // Working widths, all exact.
    localparam int C    = acit_pkg::COORD_BITS;
    localparam int AB   = acit_pkg::AXIS_BITS;
    localparam int T2W  = C + 2;          // 2*center - 2*origin
    localparam int DXW  = C + 1;          // clamp distance, extent
    localparam int PRW  = T2W + AB;       // t2 * axis
    localparam int DW   = C + 20;         // dot product
    localparam int DSW  = 2 * DXW + 2;    // sums of three squares
    localparam int RTW  = DSW / 2;        // sphere radius
    localparam int SW   = DW - 1 - acit_pkg::AXIS_FRAC;  // axial distance
    localparam int STW  = SW + acit_pkg::TAN_BITS;
    localparam int RCW  = STW - acit_pkg::TAN_FRAC;      // cone radius
    localparam int PPW  = SW + 1 + AB;    // axis * s
    localparam int PW   = C + 8;          // perpendicular component
    localparam int PSW  = 2 * PW + 2;
    localparam int LIMW = RCW + 1;
    localparam int LSW  = 2 * (LIMW + 1);
    localparam int AXL  = C + 3;          // 2*length + radius
    localparam int SQL  = RTW;            // square root latency
    localparam int PST  = 7;              // stages after the square root

    localparam logic signed [PPW-1:0] AX_HALF   = PPW'(1) <<< (acit_pkg::AXIS_FRAC - 1);
    localparam logic [STW-1:0]        TAN_ROUND = STW'((1 << acit_pkg::TAN_FRAC) - 1);

    typedef struct packed {
        logic behind;
        logic apex_in;
        logic far;
        logic axmiss;
    } flags_t;

    typedef struct packed {
        flags_t         flg;
        logic [DW-1:0]  dot;
        logic [T2W-1:0] t2_x;
        logic [T2W-1:0] t2_y;
        logic [T2W-1:0] t2_z;
    } side_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [C-1:0]                    origin_reg [3];
    logic signed [AB-1:0]                   axis_reg   [3];
    logic [acit_pkg::LEN_BITS-1:0]          len_reg;
    logic [acit_pkg::TAN_BITS-1:0]          tan_reg;
    logic [2*acit_pkg::LEN_BITS-1:0]        lensq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            axis_reg[0]   <= acit_pkg::AXIS_X_RESET;
            axis_reg[1]   <= '0;
            axis_reg[2]   <= '0;
            len_reg       <= '0;
            tan_reg       <= acit_pkg::TAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                acit_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_wdata[C-1:0];
                acit_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_wdata[C-1:0];
                acit_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_wdata[C-1:0];
                acit_pkg::REG_AXIS_X:   axis_reg[0]   <= cfg_wdata[AB-1:0];
                acit_pkg::REG_AXIS_Y:   axis_reg[1]   <= cfg_wdata[AB-1:0];
                acit_pkg::REG_AXIS_Z:   axis_reg[2]   <= cfg_wdata[AB-1:0];
                acit_pkg::REG_LENGTH:   len_reg <= cfg_wdata[acit_pkg::LEN_BITS-1:0];
                acit_pkg::REG_TAN:      tan_reg <= cfg_wdata[acit_pkg::TAN_BITS-1:0];
            endcase
        end
    end

    // length squared is registered from the length register; config is quiet
    // long before a box reaches the distance compare
    always_ff @(posedge aclk) begin
        lensq_reg <= (2*acit_pkg::LEN_BITS)'(len_reg) * (2*acit_pkg::LEN_BITS)'(len_reg);
    end

    // ---------------------------------------------------------------
    // Pipeline enable and output buffer control
    // ---------------------------------------------------------------
    logic       en;
    logic [1:0] cnt_reg;
    logic       fifo_full;
    logic       push;
    logic       pop;

    assign fifo_full = cnt_reg == 2'd2;
    assign en        = !fifo_full || m_ready;
    assign s_ready   = en;

    // ---------------------------------------------------------------
    // Stage 1: center offset, clamp distance, extents, apex-inside test
    // ---------------------------------------------------------------
    logic signed [C-1:0]   mn [3];
    logic signed [C-1:0]   mx [3];
    logic signed [C-1:0]   clamp [3];
    logic signed [T2W-1:0] t2_next [3];
    logic signed [DXW-1:0] dx_next [3];
    logic signed [DXW-1:0] ex_next [3];
    logic [2:0]            in_axis;

    assign mn[0] = s_payload.box_min_x;
    assign mn[1] = s_payload.box_min_y;
    assign mn[2] = s_payload.box_min_z;
    assign mx[0] = s_payload.box_max_x;
    assign mx[1] = s_payload.box_max_y;
    assign mx[2] = s_payload.box_max_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // inverted box clamps to min first, as intended
            if (origin_reg[i] < mn[i]) begin
                clamp[i] = mn[i];
            end else if (origin_reg[i] > mx[i]) begin
                clamp[i] = mx[i];
            end else begin
                clamp[i] = origin_reg[i];
            end
            t2_next[i] = T2W'(mn[i]) + T2W'(mx[i]) - (T2W'(origin_reg[i]) <<< 1);
            dx_next[i] = DXW'(origin_reg[i]) - DXW'(clamp[i]);
            ex_next[i] = DXW'(mx[i]) - DXW'(mn[i]);
            in_axis[i] = (mn[i] < origin_reg[i]) && (origin_reg[i] < mx[i]);
        end
    end

    logic [3:0]            v_reg;    // valids of stages 1..4
    logic signed [T2W-1:0] t2_1_reg [3];
    logic signed [T2W-1:0] t2_2_reg [3];
    logic signed [T2W-1:0] t2_3_reg [3];
    logic signed [T2W-1:0] t2_4_reg [3];
    logic signed [DXW-1:0] dx_reg [3];
    logic signed [DXW-1:0] ex_reg [3];
    logic [3:0]            inside_reg;
    logic signed [PRW-1:0] prod_reg [3];
    logic signed [DW-1:0]  dot_3_reg;
    logic signed [DW-1:0]  dot_4_reg;
    logic [DSW-1:0]        dist_reg;
    logic [DSW-1:0]        e2_reg;
    logic [2*DXW-1:0]      dx2 [3];
    logic [2*DXW-1:0]      ex2 [3];

    for (genvar i = 0; i < 3; i++) begin : g_box_sq
        acit_square #(.W(DXW)) u_dx_sq (
            .aclk (aclk),
            .en   (en),
            .din  (dx_reg[i]),
            .dout (dx2[i])
        );
        acit_square #(.W(DXW)) u_ex_sq (
            .aclk (aclk),
            .en   (en),
            .din  (ex_reg[i]),
            .dout (ex2[i])
        );
    end

    // Stages 1..4: entry, axis products, dot sum, square sums
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t2_1_reg[i] <= t2_next[i];
                dx_reg[i]   <= dx_next[i];
                ex_reg[i]   <= ex_next[i];
                prod_reg[i] <= PRW'(t2_1_reg[i]) * PRW'(axis_reg[i]);
                t2_2_reg[i] <= t2_1_reg[i];
                t2_3_reg[i] <= t2_2_reg[i];
                t2_4_reg[i] <= t2_3_reg[i];
            end
            inside_reg <= {inside_reg[2:0], &in_axis};
            dot_3_reg  <= DW'(prod_reg[0]) + DW'(prod_reg[1]) + DW'(prod_reg[2]);
            dot_4_reg  <= dot_3_reg;
            dist_reg   <= DSW'(dx2[0]) + DSW'(dx2[1]) + DSW'(dx2[2]);
            e2_reg     <= DSW'(ex2[0]) + DSW'(ex2[1]) + DSW'(ex2[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], s_valid};
        end
    end

    // ---------------------------------------------------------------
    // Sphere radius: square root of squared diagonal, sideband alongside
    // ---------------------------------------------------------------
    logic [RTW-1:0] root;
    logic           rem_nz;
    side_t          side_in;
    side_t          side_reg [SQL];
    logic [SQL-1:0] side_vld_reg;

    acit_sqrt #(.W(DSW)) u_sqrt (
        .aclk   (aclk),
        .en     (en),
        .din    (e2_reg),
        .root   (root),
        .rem_nz (rem_nz)
    );

    always_comb begin
        side_in.flg.behind  = dot_4_reg[DW-1];
        side_in.flg.apex_in = inside_reg[3];
        side_in.flg.far     = DSW'(lensq_reg) < dist_reg;
        side_in.flg.axmiss  = 1'b0;
        side_in.dot         = dot_4_reg;
        side_in.t2_x        = t2_4_reg[0];
        side_in.t2_y        = t2_4_reg[1];
        side_in.t2_z        = t2_4_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < SQL; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_vld_reg <= '0;
        end else if (en) begin
            side_vld_reg <= {side_vld_reg[SQL-2:0], v_reg[3]};
        end
    end

    // ---------------------------------------------------------------
    // Post stages: R (radius, s), P1 (axial test, products), P2 (cone radius,
    // perpendicular), P3 (limit), P4/P5 (squares), P6 (perp sum)
    // ---------------------------------------------------------------
    side_t                 sq_out;
    logic [PST-1:0]        pv_reg;
    flags_t                flg_reg [PST];
    logic [RTW-1:0]        rad_r_reg;
    logic [RTW-1:0]        rad_1_reg;
    logic [RTW-1:0]        rad_2_reg;
    logic [SW-1:0]         s_reg;
    logic [DW-1:0]         dot_r_reg;
    logic signed [T2W-1:0] t2_r_reg [3];
    logic signed [T2W-1:0] t2_p1_reg [3];
    logic [STW-1:0]        stv_reg;
    logic signed [PPW-1:0] pr_reg [3];
    logic [RCW-1:0]        rc_reg;
    logic signed [PW-1:0]  p_reg [3];
    logic signed [PW-1:0]  p3_reg [3];
    logic [LIMW-1:0]       lim_reg;
    logic [AXL-1:0]        axl;
    logic                  axmiss_next;
    logic [2*PW-1:0]       p2 [3];
    logic [LSW-1:0]        limsq;
    logic [PSW-1:0]        perp_reg;
    logic [LSW-1:0]        limsq_reg;

    assign sq_out      = side_reg[SQL-1];
    assign axl         = (AXL'(len_reg) << 1) + AXL'(rad_r_reg);
    assign axmiss_next = (DW'(axl) << acit_pkg::AXIS_FRAC) < dot_r_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // R: round the radius up, floor the axial distance
            rad_r_reg   <= root + RTW'(rem_nz);
            s_reg       <= sq_out.dot[DW-2:acit_pkg::AXIS_FRAC];
            dot_r_reg   <= sq_out.dot;
            t2_r_reg[0] <= sq_out.t2_x;
            t2_r_reg[1] <= sq_out.t2_y;
            t2_r_reg[2] <= sq_out.t2_z;
            flg_reg[0]  <= sq_out.flg;

            // P1
            flg_reg[1] <= {flg_reg[0].behind, flg_reg[0].apex_in, flg_reg[0].far,
                           axmiss_next};
            rad_1_reg  <= rad_r_reg;
            stv_reg    <= STW'(s_reg) * STW'(tan_reg);
            for (int i = 0; i < 3; i++) begin
                pr_reg[i]    <= PPW'(axis_reg[i]) * PPW'($signed({1'b0, s_reg})) + AX_HALF;
                t2_p1_reg[i] <= t2_r_reg[i];
            end

            // P2: cone radius rounds up, axial point rounds half up
            flg_reg[2] <= flg_reg[1];
            rad_2_reg  <= rad_1_reg;
            rc_reg     <= RCW'((stv_reg + TAN_ROUND) >> acit_pkg::TAN_FRAC);
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= PW'(t2_p1_reg[i]) - PW'(pr_reg[i] >>> acit_pkg::AXIS_FRAC);
            end

            // P3
            flg_reg[3] <= flg_reg[2];
            lim_reg    <= LIMW'(rc_reg) + LIMW'(rad_2_reg);
            for (int i = 0; i < 3; i++) begin
                p3_reg[i] <= p_reg[i];
            end

            // P4, P5: squarers run
            flg_reg[4] <= flg_reg[3];
            flg_reg[5] <= flg_reg[4];

            // P6
            flg_reg[6] <= flg_reg[5];
            perp_reg   <= PSW'(p2[0]) + PSW'(p2[1]) + PSW'(p2[2]);
            limsq_reg  <= limsq;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_perp_sq
        acit_square #(.W(PW)) u_p_sq (
            .aclk (aclk),
            .en   (en),
            .din  (p3_reg[i]),
            .dout (p2[i])
        );
    end

    acit_square #(.W(LIMW + 1)) u_lim_sq (
        .aclk (aclk),
        .en   (en),
        .din  ($signed({1'b0, lim_reg})),
        .dout (limsq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (en) begin
            pv_reg <= {pv_reg[PST-2:0], side_vld_reg[SQL-1]};
        end
    end

    // ---------------------------------------------------------------
    // Decision
    // ---------------------------------------------------------------
    acit_pkg::test_result_t res;
    flags_t                 fl;

    assign fl = flg_reg[PST-1];

    always_comb begin
        res.hit     = 1'b0;
        res.outcome = acit_pkg::OUT_BEHIND;
        if (fl.behind) begin
            res.hit     = fl.apex_in;
            res.outcome = fl.apex_in ? acit_pkg::OUT_ORIGIN_IN : acit_pkg::OUT_BEHIND;
        end else if (fl.far) begin
            res.outcome = acit_pkg::OUT_TOO_FAR;
        end else if (fl.axmiss) begin
            res.outcome = acit_pkg::OUT_AXIAL_MISS;
        end else if (limsq_reg < LSW'(perp_reg)) begin
            res.outcome = acit_pkg::OUT_OUTSIDE;
        end else begin
            res.hit     = 1'b1;
            res.outcome = acit_pkg::OUT_IN_CONE;
        end
    end

    // ---------------------------------------------------------------
    // Two-entry output buffer
    // ---------------------------------------------------------------
    acit_pkg::test_result_t fifo_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;

    assign push      = en && pv_reg[PST-1];
    assign pop       = m_valid && m_ready;
    assign m_valid   = cnt_reg != 2'd0;
    assign m_payload = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && fifo_full) |-> pop)
        else $error("result pushed into a full buffer");

    a_hit_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.hit == ((m_payload.outcome == acit_pkg::OUT_IN_CONE) ||
                                       (m_payload.outcome == acit_pkg::OUT_ORIGIN_IN))))
        else $error("hit flag disagrees with outcome");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.outcome <= acit_pkg::OUT_IN_CONE))
        else $error("outcome code out of range");

endmodule

// ===== bench/acit_checker.sv =====
// Checker for the cone/box test: predicts each result and compares it with the block's output.
`timescale 1ns / 100ps

module acit_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  acit_pkg::box_item_t                 s_payload,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  acit_pkg::test_result_t              m_payload,
    input  logic                                cfg_wr_en,
    input  logic [acit_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [acit_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output int                                  errors,
    output int                                  pending
);

    typedef logic signed [127:0] wide_t;

    logic signed [acit_pkg::COORD_BITS-1:0] apex [3];
    logic signed [acit_pkg::AXIS_BITS-1:0]  axis [3];
    logic [acit_pkg::LEN_BITS-1:0]          cone_len;
    logic [acit_pkg::TAN_BITS-1:0]          tan_half;

    acit_pkg::test_result_t expected_results[$];

    function automatic acit_pkg::test_result_t predict_contact(acit_pkg::box_item_t b);
        wide_t                  mn[3], mx[3], o[3], a[3], t2[3];
        wide_t                  dot, dist_sq, e2, perp, q, d, w, pr, p;
        wide_t                  len, tanv, rad, cand, s, rc, lim;
        acit_pkg::test_result_t r;
        logic                   apex_in;
        mn[0] = b.box_min_x; mn[1] = b.box_min_y; mn[2] = b.box_min_z;
        mx[0] = b.box_max_x; mx[1] = b.box_max_y; mx[2] = b.box_max_z;
        dot = 0; dist_sq = 0; e2 = 0; perp = 0;
        for (int i = 0; i < 3; i++) begin
            o[i]  = apex[i];
            a[i]  = axis[i];
            t2[i] = mn[i] + mx[i] - 2 * o[i];
            dot   = dot + t2[i] * a[i];
        end
        len  = {97'd0, cone_len};
        tanv = {112'd0, tan_half};
        r.hit = 1'b0;
        if (dot < 0) begin
            apex_in = 1'b1;
            for (int i = 0; i < 3; i++)
                if (!(mn[i] < o[i] && o[i] < mx[i])) apex_in = 1'b0;
            r.hit     = apex_in;
            r.outcome = apex_in ? acit_pkg::OUT_ORIGIN_IN : acit_pkg::OUT_BEHIND;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            q = o[i];
            if (o[i] < mn[i]) q = mn[i];
            else if (o[i] > mx[i]) q = mx[i];
            d       = o[i] - q;
            dist_sq = dist_sq + d * d;
            w       = mx[i] - mn[i];
            e2      = e2 + w * w;
        end
        if (len * len < dist_sq) begin
            r.outcome = acit_pkg::OUT_TOO_FAR;
            return r;
        end
        // ceiling square root of the squared diagonal
        rad = 0;
        for (int k = 63; k >= 0; k--) begin
            cand = rad | (wide_t'(1) << k);
            if (!(e2 < cand * cand)) rad = cand;
        end
        if (rad * rad < e2) rad = rad + 1;
        s = dot >>> acit_pkg::AXIS_FRAC;
        if (((2 * len + rad) <<< acit_pkg::AXIS_FRAC) < dot) begin
            r.outcome = acit_pkg::OUT_AXIAL_MISS;
            return r;
        end
        rc = (s * tanv + 255) >>> acit_pkg::TAN_FRAC;
        for (int i = 0; i < 3; i++) begin
            pr   = a[i] * s + 8192;
            p    = t2[i] - (pr >>> acit_pkg::AXIS_FRAC);
            perp = perp + p * p;
        end
        lim = rc + rad;
        if (lim * lim < perp) begin
            r.outcome = acit_pkg::OUT_OUTSIDE;
        end else begin
            r.hit     = 1'b1;
            r.outcome = acit_pkg::OUT_IN_CONE;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        acit_pkg::test_result_t want;
        if (!aresetn) begin
            apex[0]  <= '0;
            apex[1]  <= '0;
            apex[2]  <= '0;
            axis[0]  <= acit_pkg::AXIS_X_RESET;
            axis[1]  <= '0;
            axis[2]  <= '0;
            cone_len <= '0;
            tan_half <= acit_pkg::TAN_RESET;
            expected_results.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_contact(s_payload));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b outcome=%0d",
                             $time, m_payload.hit, m_payload.outcome);
                    errors <= errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.hit !== m_payload.hit || want.outcome !== m_payload.outcome) begin
                        $display("%0t: mismatch expected hit=%0b outcome=%0d, got hit=%0b outcome=%0d",
                                 $time, want.hit, want.outcome, m_payload.hit, m_payload.outcome);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_results.size();
            if (cfg_wr_en) begin
                case (cfg_index)
                    acit_pkg::REG_ORIGIN_X: apex[0]  <= cfg_wdata;
                    acit_pkg::REG_ORIGIN_Y: apex[1]  <= cfg_wdata;
                    acit_pkg::REG_ORIGIN_Z: apex[2]  <= cfg_wdata;
                    acit_pkg::REG_AXIS_X:   axis[0]  <= cfg_wdata[acit_pkg::AXIS_BITS-1:0];
                    acit_pkg::REG_AXIS_Y:   axis[1]  <= cfg_wdata[acit_pkg::AXIS_BITS-1:0];
                    acit_pkg::REG_AXIS_Z:   axis[2]  <= cfg_wdata[acit_pkg::AXIS_BITS-1:0];
                    acit_pkg::REG_LENGTH:   cone_len <= cfg_wdata[acit_pkg::LEN_BITS-1:0];
                    acit_pkg::REG_TAN:      tan_half <= cfg_wdata[acit_pkg::TAN_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the cone/box test bench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT  = 4000;  // cycles without any transfer before giving up
    localparam int DRAIN_WAIT  = 60;    // pipeline is 45 deep
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 136;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    acit_pkg::box_item_t                 s_payload = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    acit_pkg::test_result_t              m_payload;
    logic                                cfg_wr_en = 1'b0;
    logic [acit_pkg::CFG_INDEX_BITS-1:0] cfg_index = acit_pkg::REG_ORIGIN_X;
    logic [acit_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    int                                  errors;
    int                                  pending;

    // apex as the bench last programmed it, used to aim boxes
    int signed apex_x, apex_y, apex_z;
    int        burst_left = 0;
    int        idle_cycles = 0;
    int        cycle_count = 0;

    always #4 aclk = ~aclk;

    aabb_cone_intersect_test dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    acit_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // Receiver stalls: the mode steps with bits 10:8 of the cycle count, so that long
    // always-ready stretches alternate with light, heavy and periodic stalls.
    always @(negedge aclk) begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[10:8] % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (cycle_count[2:0] != 3'd5) && (cycle_count[4:3] != 2'd2);
        endcase
    end

    // Watchdog: any transfer on either channel resets the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic acit_pkg::box_item_t make_box(int signed cx, int signed cy,
                                                     int signed cz, int signed hx,
                                                     int signed hy, int signed hz);
        acit_pkg::box_item_t b;
        b.box_min_x = cx - hx; b.box_max_x = cx + hx;
        b.box_min_y = cy - hy; b.box_max_y = cy + hy;
        b.box_min_z = cz - hz; b.box_max_z = cz + hz;
        return b;
    endfunction

    function automatic int signed spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly boxes aimed near the apex at the phase's scale; some inverted,
    // some fully random words, a few huge boxes around the apex.
    function automatic acit_pkg::box_item_t random_box(int span);
        acit_pkg::box_item_t b;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            b = make_box(apex_x + spread(span), apex_y + spread(span), apex_z + spread(span),
                         $urandom_range(0, span / 2), $urandom_range(0, span / 2),
                         $urandom_range(0, span / 2));
        end else if (pick < 85) begin
            b = make_box(apex_x + spread(span), apex_y + spread(span), apex_z + spread(span),
                         -int'($urandom_range(0, span / 2)), $urandom_range(0, span / 2),
                         -int'($urandom_range(0, span / 2)));
        end else if (pick < 95) begin
            b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            b = make_box(apex_x + spread(4), apex_y + spread(4), apex_z + spread(4),
                         span * 4, span * 4, span * 4);
        end
        return b;
    endfunction

    // One input transfer; valid stays high from item to item inside a burst.
    task automatic send_box(input acit_pkg::box_item_t b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_payload = b;
        s_valid   = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [acit_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [acit_pkg::CFG_DATA_BITS-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Drain everything in flight; results never come for nothing, so a
    // latency-sized pause after the last one leaves the pipe empty.
    task automatic wait_idle();
        s_valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic program_cone(input int signed ox, input int signed oy, input int signed oz,
                                input int signed ax, input int signed ay, input int signed az,
                                input logic [30:0] len, input logic [15:0] tanv);
        write_reg(acit_pkg::REG_ORIGIN_X, ox);
        write_reg(acit_pkg::REG_ORIGIN_Y, oy);
        write_reg(acit_pkg::REG_ORIGIN_Z, oz);
        write_reg(acit_pkg::REG_AXIS_X, ax);
        write_reg(acit_pkg::REG_AXIS_Y, ay);
        write_reg(acit_pkg::REG_AXIS_Z, az);
        write_reg(acit_pkg::REG_LENGTH, {1'b0, len});
        write_reg(acit_pkg::REG_TAN, {16'd0, tanv});
        apex_x = ox; apex_y = oy; apex_z = oz;
    endtask

    initial begin
        int span;
        int signed ax, ay, az;
        logic [15:0] tanv;
        apex_x = 0; apex_y = 0; apex_z = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed, reset settings: apex 0, axis +x, zero length, tan 1.0.
        send_box(make_box(0, 0, 0, 2, 2, 2));            // touches apex, zero length passes
        send_box(make_box(-512, 0, 0, 256, 256, 256));   // behind, apex outside
        send_box(make_box(-100, 0, 0, 200, 30, 30));     // behind, apex strictly inside
        send_box(make_box(5000, 0, 0, 10, 10, 10));      // far beyond zero length
        send_box(make_box(10, 10, 10, -20, 5, 5));       // inverted x
        send_box({32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        send_box({32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000});
        send_box('0);
        send_box('1);
        wait_idle();

        // Directed with a real cone: length 1000, 45 degree half angle.
        program_cone(0, 0, 0, 16384, 0, 0, 31'd256000, 16'd256);
        send_box(make_box(128000, 0, 0, 256, 256, 256));      // in cone
        send_box(make_box(128000, 120000, 0, 256, 256, 256)); // in cone near edge
        send_box(make_box(128000, 0, 200000, 256, 256, 256)); // outside cone
        send_box(make_box(600000, 0, 0, 256, 256, 256));      // too far
        send_box(make_box(250000, 0, 0, 1000, 1000, 1000));   // near the end cap
        send_box(make_box(-256000, 0, 0, 512, 512, 512));     // behind
        send_box(make_box(-20, 0, 0, 100, 100, 100));         // apex inside, centre behind
        send_box(make_box(100, -5, 3, -50, 50, -50));         // inverted box in front
        send_box(make_box(0, 0, 0, 300000, 300000, 300000));  // huge box around apex
        wait_idle();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            span = 1 << $urandom_range(4, 22);
            case (ph)
                0: program_cone(32'sh7fffffff, 32'sh80000000, 0, -16384, 0, 0,
                                31'h7fffffff, 16'hffff);
                1: program_cone(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 16384, -16384,
                                31'd0, 16'd0);
                2: program_cone(0, 0, 0, 0, 0, 16384, 31'(span), 16'd0);
                3: program_cone(spread(span), spread(span), spread(span), 0, -16384, 0,
                                31'(span), 16'hffff);
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        ax = spread(16384); ay = spread(16384); az = spread(16384);
                    end else begin
                        ax = 0; ay = 0; az = 0;
                        case ($urandom_range(0, 2))
                            0: ax = $urandom_range(0, 1) ? 16384 : -16384;
                            1: ay = $urandom_range(0, 1) ? 16384 : -16384;
                            default: az = $urandom_range(0, 1) ? 16384 : -16384;
                        endcase
                    end
                    tanv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
                    program_cone($urandom, $urandom, $urandom, ax, ay, az,
                                 31'($urandom_range(span / 2, span * 2)), tanv);
                    // keep the origin moderate on half the phases so boxes do not wrap
                    if ($urandom_range(0, 1) == 1)
                        program_cone(spread(1 << 24), spread(1 << 24), spread(1 << 24),
                                     ax, ay, az, 31'($urandom_range(span / 2, span * 2)), tanv);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_box(random_box(span));
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
